@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Needs nothing else; each macro takes a label, clock, active-low reset and two terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/gpr_pkg.sv @@
// Shared types and constants for the graph pair reachability block.
// No dependencies; imported by every module of the block.
package gpr_pkg;

    localparam int NODES = 8;
    localparam int IDX_W = $clog2(NODES);
    localparam int NODE_FW = 4;
    localparam int CNT_W = 6;

    typedef logic [NODES-1:0] t_row;
    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_SWEEP = 2'd2
    } t_action;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_mem_rd;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_row data;
    } t_mem_wr;

    typedef struct packed {
        logic start;
        t_idx src;
    } t_srch_req;

    typedef struct packed {
        logic done;
        t_row visited;
    } t_srch_stat;

endpackage

@@ rtl/gpr_adj_mem.sv @@
// Adjacency row memory with registered read and per-row valid bits.
// Depends on gpr_pkg; rows never written read as zero after reset.
module gpr_adj_mem
    import gpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mem_rd i_rd,
    input  t_mem_wr i_wr,
    output t_row    o_rdata
);

    t_row             r_mem [NODES];
    logic [NODES-1:0] r_valid;
    t_row             r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rvalid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ rtl/gpr_search.sv @@
// Reachability search: grows the visited set from one source, one memory row per step.
// Depends on gpr_pkg; reads rows through the adjacency memory port.
module gpr_search
    import gpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_srch_req  i_req,
    input  t_row       i_rdata,
    output t_mem_rd    o_rd,
    output t_srch_stat o_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_POP  = 4'b0100,
        S_WAIT = 4'b1000
    } t_sstate;

    t_sstate r_state, n_state;
    t_row    r_visited, n_visited;
    t_row    r_frontier, n_frontier;
    t_idx    pick;
    logic    done;

    function automatic t_idx low_idx(t_row v);
        t_idx idx;
        idx = '0;
        for (int k = NODES - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = t_idx'(k);
            end
        end
        return idx;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_visited  = r_visited;
        n_frontier = r_frontier;
        o_rd       = '0;
        done       = 1'b0;
        pick       = low_idx(r_frontier);
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = i_req.src;
                    n_state   = S_ROOT;
                end
            end
            S_ROOT: begin
                n_visited  = i_rdata;
                n_frontier = i_rdata;
                n_state    = S_POP;
            end
            S_POP: begin
                if (r_frontier == '0) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_rd.en    = 1'b1;
                    o_rd.addr  = pick;
                    n_frontier = r_frontier & ~(t_row'(1) << pick);
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                n_visited  = r_visited | i_rdata;
                n_frontier = r_frontier | (i_rdata & ~r_visited);
                n_state    = S_POP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_visited  <= '0;
            r_frontier <= '0;
        end else begin
            r_state    <= n_state;
            r_visited  <= n_visited;
            r_frontier <= n_frontier;
        end
    end

    assign o_stat.done    = done;
    assign o_stat.visited = r_visited;

endmodule

@@ rtl/graph_pair_reachability.sv @@
// Top level of the graph pair reachability block: command sequencer and result registers.
// Depends on gpr_pkg, gpr_adj_mem and gpr_search.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------------
//  input   | start, busy               | i_action, i_from_node, i_to_node
//  result  | o_result_valid (strobe)   | o_pair_from, o_pair_to, o_no_path, o_is_summary,
//          |                           | o_failure_count, o_bad_node, o_last
//
// An add reads and then writes one adjacency row.
// A query runs one search, reading the source row and then one row per node reached.
// A sweep runs, for each source in turn, one search and then a scan of NODES
// destinations, and ends with a summary result.
// Reset clears the control state and the row valid bits; results cannot be stalled.
module graph_pair_reachability
    import gpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [NODE_FW-1:0] i_from_node,
    input  logic [NODE_FW-1:0] i_to_node,
    output logic               o_result_valid,
    output logic [NODE_FW-1:0] o_pair_from,
    output logic [NODE_FW-1:0] o_pair_to,
    output logic               o_no_path,
    output logic               o_is_summary,
    output logic [CNT_W-1:0]   o_failure_count,
    output logic               o_bad_node,
    output logic               o_last
);

    typedef enum logic [5:0] {
        C_IDLE   = 6'b000001,
        C_ADD_RD = 6'b000010,
        C_ADD_WR = 6'b000100,
        C_SRCH   = 6'b001000,
        C_SCAN   = 6'b010000,
        C_SUM    = 6'b100000
    } t_cstate;

    t_cstate            r_state, n_state;
    logic               r_sweep, n_sweep;
    t_idx               r_src, n_src;
    t_idx               r_dst, n_dst;
    t_idx               r_j, n_j;
    logic [NODE_FW-1:0] r_fn, n_fn;
    logic [NODE_FW-1:0] r_tn, n_tn;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               r_ovalid, n_ovalid;
    logic [NODE_FW-1:0] r_opf, n_opf;
    logic [NODE_FW-1:0] r_opt, n_opt;
    logic               r_onp, n_onp;
    logic               r_osum, n_osum;
    logic [CNT_W-1:0]   r_ocnt, n_ocnt;
    logic               r_obad, n_obad;
    logic               r_olast, n_olast;

    t_mem_rd            c_rd, s_rd, mem_rd;
    t_mem_wr            mem_wr;
    t_row               rdata;
    t_srch_req          s_req;
    t_srch_stat         s_stat;
    logic               accept, in_ok;
    logic [NODE_FW-1:0] fn_m1, tn_m1;
    t_action            act;

    gpr_adj_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (mem_rd),
        .i_wr    (mem_wr),
        .o_rdata (rdata)
    );

    gpr_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .i_rdata (rdata),
        .o_rd    (s_rd),
        .o_stat  (s_stat)
    );

    assign mem_rd = s_rd.en ? s_rd : c_rd;
    assign busy   = (r_state != C_IDLE);
    assign accept = start && !busy;
    assign act    = t_action'(i_action);
    assign fn_m1  = i_from_node - NODE_FW'(1);
    assign tn_m1  = i_to_node - NODE_FW'(1);
    assign in_ok  = (i_from_node >= NODE_FW'(1)) && (i_from_node <= NODE_FW'(NODES))
                 && (i_to_node >= NODE_FW'(1)) && (i_to_node <= NODE_FW'(NODES));

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_src    = r_src;
        n_dst    = r_dst;
        n_j      = r_j;
        n_fn     = r_fn;
        n_tn     = r_tn;
        n_cnt    = r_cnt;
        n_ovalid = 1'b0;
        n_opf    = r_opf;
        n_opt    = r_opt;
        n_onp    = r_onp;
        n_osum   = r_osum;
        n_ocnt   = r_ocnt;
        n_obad   = r_obad;
        n_olast  = r_olast;
        c_rd     = '0;
        mem_wr   = '0;
        s_req    = '0;
        unique case (r_state)
            C_IDLE: begin
                if (accept) begin
                    n_fn = i_from_node;
                    n_tn = i_to_node;
                    unique case (act)
                        ACT_ADD: begin
                            if (in_ok) begin
                                c_rd.en   = 1'b1;
                                c_rd.addr = fn_m1[IDX_W-1:0];
                                n_src     = fn_m1[IDX_W-1:0];
                                n_dst     = tn_m1[IDX_W-1:0];
                                n_state   = C_ADD_RD;
                            end
                        end
                        ACT_QUERY: begin
                            if (in_ok) begin
                                s_req.start = 1'b1;
                                s_req.src   = fn_m1[IDX_W-1:0];
                                n_src       = fn_m1[IDX_W-1:0];
                                n_dst       = tn_m1[IDX_W-1:0];
                                n_sweep     = 1'b0;
                                n_state     = C_SRCH;
                            end else begin
                                n_ovalid = 1'b1;
                                n_opf    = i_from_node;
                                n_opt    = i_to_node;
                                n_onp    = 1'b0;
                                n_osum   = 1'b0;
                                n_ocnt   = '0;
                                n_obad   = 1'b1;
                                n_olast  = 1'b1;
                            end
                        end
                        ACT_SWEEP: begin
                            s_req.start = 1'b1;
                            s_req.src   = '0;
                            n_src       = '0;
                            n_cnt       = '0;
                            n_sweep     = 1'b1;
                            n_state     = C_SRCH;
                        end
                        default: begin
                            n_state = C_IDLE;
                        end
                    endcase
                end
            end
            C_ADD_RD: begin
                n_state = C_ADD_WR;
            end
            C_ADD_WR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_src;
                mem_wr.data = rdata | (t_row'(1) << r_dst);
                n_state     = C_IDLE;
            end
            C_SRCH: begin
                if (s_stat.done) begin
                    if (r_sweep) begin
                        n_j     = '0;
                        n_state = C_SCAN;
                    end else begin
                        n_ovalid = 1'b1;
                        n_opf    = r_fn;
                        n_opt    = r_tn;
                        n_onp    = !s_stat.visited[r_dst];
                        n_osum   = 1'b0;
                        n_ocnt   = '0;
                        n_obad   = 1'b0;
                        n_olast  = 1'b1;
                        n_state  = C_IDLE;
                    end
                end
            end
            C_SCAN: begin
                if ((r_j != r_src) && !s_stat.visited[r_j]) begin
                    n_ovalid = 1'b1;
                    n_opf    = NODE_FW'(r_src) + NODE_FW'(1);
                    n_opt    = NODE_FW'(r_j) + NODE_FW'(1);
                    n_onp    = 1'b1;
                    n_osum   = 1'b0;
                    n_ocnt   = '0;
                    n_obad   = 1'b0;
                    n_olast  = 1'b0;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
                if (r_j == IDX_W'(NODES - 1)) begin
                    if (r_src == IDX_W'(NODES - 1)) begin
                        n_state = C_SUM;
                    end else begin
                        s_req.start = 1'b1;
                        s_req.src   = r_src + IDX_W'(1);
                        n_src       = r_src + IDX_W'(1);
                        n_state     = C_SRCH;
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            C_SUM: begin
                n_ovalid = 1'b1;
                n_opf    = '0;
                n_opt    = '0;
                n_onp    = 1'b0;
                n_osum   = 1'b1;
                n_ocnt   = r_cnt;
                n_obad   = 1'b0;
                n_olast  = 1'b1;
                n_state  = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_sweep  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_j     <= n_j;
        r_fn    <= n_fn;
        r_tn    <= n_tn;
        r_cnt   <= n_cnt;
        r_opf   <= n_opf;
        r_opt   <= n_opt;
        r_onp   <= n_onp;
        r_osum  <= n_osum;
        r_ocnt  <= n_ocnt;
        r_obad  <= n_obad;
        r_olast <= n_olast;
    end

    assign o_result_valid  = r_ovalid;
    assign o_pair_from     = r_opf;
    assign o_pair_to       = r_opt;
    assign o_no_path       = r_onp;
    assign o_is_summary    = r_osum;
    assign o_failure_count = r_ocnt;
    assign o_bad_node      = r_obad;
    assign o_last          = r_olast;

endmodule

@@ rtl/gpr_checker.sv @@
// Port-level checker for the graph pair reachability block, bound to the top level.
// Depends on gpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpr_checker
    import gpr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_action,
    input logic [NODE_FW-1:0] i_from_node,
    input logic [NODE_FW-1:0] i_to_node,
    input logic               o_result_valid,
    input logic [NODE_FW-1:0] o_pair_from,
    input logic [NODE_FW-1:0] o_pair_to,
    input logic               o_no_path,
    input logic               o_is_summary,
    input logic [CNT_W-1:0]   o_failure_count,
    input logic               o_bad_node,
    input logic               o_last
);

    logic bad_query;

    assign bad_query = start && !busy && (i_action == ACT_QUERY)
                    && ((i_from_node == '0) || (i_from_node > NODE_FW'(NODES))
                     || (i_to_node == '0) || (i_to_node > NODE_FW'(NODES)));

    `ASSERT_SAME(a_summary_closes, i_clk, i_rst_n, o_result_valid && o_is_summary,
        o_last && !o_no_path && !o_bad_node && (o_pair_from == '0))
    `ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_result_valid && o_last, !busy)
    `ASSERT_SAME(a_pair_busy, i_clk, i_rst_n, o_result_valid && !o_last, busy && o_no_path)
    `ASSERT_NEXT(a_bad_query, i_clk, i_rst_n, bad_query,
        o_result_valid && o_bad_node && o_last && !o_no_path)
    `ASSERT_NEXT(a_sweep_busy, i_clk, i_rst_n, start && !busy && (i_action == ACT_SWEEP), busy)

endmodule

bind graph_pair_reachability gpr_checker u_gpr_checker (.*);

@@ dv/graph_pair_reachability_tb.sv @@
// Self-checking testbench for graph_pair_reachability: edge adds, pair queries and sweeps.
// Depends on gpr_pkg and the graph_pair_reachability RTL; predicts results with its own graph.
module graph_pair_reachability_tb;
    import gpr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 196;

    typedef struct {
        logic [1:0]         action;
        logic [NODE_FW-1:0] from_node;
        logic [NODE_FW-1:0] to_node;
    } t_command;

    typedef struct packed {
        logic [NODE_FW-1:0] pair_from;
        logic [NODE_FW-1:0] pair_to;
        logic               no_path;
        logic               is_summary;
        logic [CNT_W-1:0]   failure_count;
        logic               bad_node;
        logic               last;
    } t_reach_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_action;
    logic [NODE_FW-1:0] i_from_node;
    logic [NODE_FW-1:0] i_to_node;
    logic               o_result_valid;
    logic [NODE_FW-1:0] o_pair_from;
    logic [NODE_FW-1:0] o_pair_to;
    logic               o_no_path;
    logic               o_is_summary;
    logic [CNT_W-1:0]   o_failure_count;
    logic               o_bad_node;
    logic               o_last;

    t_command      pending_cmds[$];
    t_reach_result expected_results[$];
    t_row          adj_rows[NODES];

    int items_issued = 0;
    int items_accepted = 0;
    int gap_left = 0;
    int no_idle_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int unreachable_seen = 0;
    int n_adds = 0;
    int n_queries = 0;
    int n_sweeps = 0;

    graph_pair_reachability dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_from_node     (i_from_node),
        .i_to_node       (i_to_node),
        .o_result_valid  (o_result_valid),
        .o_pair_from     (o_pair_from),
        .o_pair_to       (o_pair_to),
        .o_no_path       (o_no_path),
        .o_is_summary    (o_is_summary),
        .o_failure_count (o_failure_count),
        .o_bad_node      (o_bad_node),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit node_ok(logic [NODE_FW-1:0] n);
        return n >= 1 && n <= NODES;
    endfunction

    // Breadth-first closure from the successors of src; true when dst was reached.
    function automatic bit path_exists(int src, int dst);
        t_row seen;
        t_row wave;
        t_row grown;
        int   step;
        seen = '0;
        wave = adj_rows[src];
        for (step = 0; step < NODES && wave != '0; step++) begin
            seen |= wave;
            grown = '0;
            for (int k = 0; k < NODES; k++) begin
                if (wave[k]) begin
                    grown |= adj_rows[k];
                end
            end
            wave = grown & ~seen;
        end
        return seen[dst];
    endfunction

    task automatic predict_command(logic [1:0] act, logic [NODE_FW-1:0] fn,
                                   logic [NODE_FW-1:0] tn);
        t_reach_result r;
        bit            ok;
        int            fails;
        ok = node_ok(fn) && node_ok(tn);
        r = '0;
        fails = 0;
        case (act)
            ACT_ADD: begin
                n_adds++;
                if (ok) begin
                    adj_rows[fn - 1][tn - 1] = 1'b1;
                end
            end
            ACT_QUERY: begin
                n_queries++;
                r.pair_from = fn;
                r.pair_to = tn;
                r.last = 1'b1;
                if (ok) begin
                    r.no_path = !path_exists(fn - 1, tn - 1);
                end else begin
                    r.bad_node = 1'b1;
                end
                expected_results.push_back(r);
            end
            ACT_SWEEP: begin
                n_sweeps++;
                for (int i = 0; i < NODES; i++) begin
                    for (int j = 0; j < NODES; j++) begin
                        if (i != j && !path_exists(i, j)) begin
                            r = '0;
                            r.pair_from = NODE_FW'(i + 1);
                            r.pair_to = NODE_FW'(j + 1);
                            r.no_path = 1'b1;
                            expected_results.push_back(r);
                            fails++;
                        end
                    end
                end
                r = '0;
                r.is_summary = 1'b1;
                r.failure_count = CNT_W'(fails);
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_cmd(logic [1:0] act, logic [NODE_FW-1:0] fn,
                             logic [NODE_FW-1:0] tn);
        t_command c;
        c.action = act;
        c.from_node = fn;
        c.to_node = tn;
        pending_cmds.push_back(c);
    endtask

    function automatic int draw_gap();
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            no_idle_left = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // Driver: an item is taken at the rising edge where start is high and busy is low.
    always @(negedge i_clk) begin
        t_command c;
        bit       waiting;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            waiting = start && (items_accepted != items_issued);
            if (!waiting) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                    i_action <= 2'($urandom);
                    i_from_node <= NODE_FW'($urandom);
                    i_to_node <= NODE_FW'($urandom);
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds.pop_front();
                    i_action <= c.action;
                    i_from_node <= c.from_node;
                    i_to_node <= c.to_node;
                    start <= 1'b1;
                    items_issued <= items_issued + 1;
                    gap_left <= draw_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each strobed result, then predicts for any item taken this edge.
    always @(posedge i_clk) begin
        t_reach_result want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result from %0d to %0d arrived with nothing expected",
                           o_pair_from, o_pair_to);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.no_path) begin
                        unreachable_seen++;
                    end
                    check_field("pair_from", want.pair_from, o_pair_from);
                    check_field("pair_to", want.pair_to, o_pair_to);
                    check_field("no_path", want.no_path, o_no_path);
                    check_field("is_summary", want.is_summary, o_is_summary);
                    check_field("failure_count", want.failure_count, o_failure_count);
                    check_field("bad_node", want.bad_node, o_bad_node);
                    check_field("last", want.last, o_last);
                end
            end
            if (start && !busy) begin
                items_accepted <= items_accepted + 1;
                predict_command(i_action, i_from_node, i_to_node);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out with %0d results still expected.", expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int counted;
        int pick;
        logic [1:0] act;
        logic [NODE_FW-1:0] fn;
        logic [NODE_FW-1:0] tn;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ACT_ADD;
        i_from_node = '0;
        i_to_node = '0;
        for (int i = 0; i < NODES; i++) begin
            adj_rows[i] = '0;
        end

        // Directed part: empty graph, repeated edges, bad nodes, self pairs and cycles.
        queue_cmd(ACT_QUERY, 4'd1, 4'd1);
        queue_cmd(ACT_SWEEP, 4'd0, 4'd0);
        queue_cmd(ACT_ADD, 4'd1, 4'd8);
        queue_cmd(ACT_ADD, 4'd8, 4'd1);
        queue_cmd(ACT_ADD, 4'd1, 4'd8);
        queue_cmd(ACT_ADD, 4'd0, 4'd3);
        queue_cmd(ACT_ADD, 4'd9, 4'd2);
        queue_cmd(ACT_ADD, 4'd15, 4'd15);
        queue_cmd(ACT_ADD, 4'd4, 4'd0);
        queue_cmd(ACT_QUERY, 4'd1, 4'd1);
        queue_cmd(ACT_QUERY, 4'd8, 4'd8);
        queue_cmd(ACT_QUERY, 4'd2, 4'd3);
        queue_cmd(ACT_QUERY, 4'd0, 4'd5);
        queue_cmd(ACT_QUERY, 4'd5, 4'd15);
        queue_cmd(ACT_QUERY, 4'd15, 4'd0);
        queue_cmd(ACT_UNUSED, 4'd15, 4'd15);
        queue_cmd(ACT_UNUSED, 4'd0, 4'd0);
        queue_cmd(ACT_ADD, 4'd2, 4'd3);
        queue_cmd(ACT_ADD, 4'd3, 4'd2);
        queue_cmd(ACT_ADD, 4'd5, 4'd5);
        queue_cmd(ACT_QUERY, 4'd5, 4'd5);
        queue_cmd(ACT_QUERY, 4'd3, 4'd3);
        queue_cmd(ACT_SWEEP, 4'd15, 4'd0);
        queue_cmd(ACT_QUERY, 4'd1, 4'd2);

        // Random part: mostly legal adds and queries, so the graph fills in gradually.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            fn = NODE_FW'($urandom_range(1, NODES));
            tn = NODE_FW'($urandom_range(1, NODES));
            if (pick < 12) begin
                act = ACT_ADD;
            end else if (pick < 60) begin
                act = ACT_QUERY;
            end else if (pick < 68) begin
                act = ACT_SWEEP;
                fn = NODE_FW'($urandom);
                tn = NODE_FW'($urandom);
            end else if (pick < 80) begin
                act = ACT_QUERY;
                fn = NODE_FW'($urandom);
                tn = NODE_FW'($urandom);
            end else if (pick < 90) begin
                act = ACT_ADD;
                fn = NODE_FW'($urandom);
                tn = NODE_FW'($urandom);
            end else begin
                act = ACT_UNUSED;
                fn = NODE_FW'($urandom);
                tn = NODE_FW'($urandom);
            end
            queue_cmd(act, fn, tn);
            counted++;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_cmds.size() != 0 || items_accepted != items_issued) begin
            @(negedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Ran %0d items: %0d adds, %0d queries, %0d sweeps.",
                 items_accepted, n_adds, n_queries, n_sweeps);
        $display("Checked %0d results, %0d of them unreachable pairs; %0d mismatches.",
                 results_checked, unreachable_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gpr_pkg.sv
rtl/gpr_adj_mem.sv
rtl/gpr_search.sv
rtl/graph_pair_reachability.sv
rtl/gpr_checker.sv
dv/graph_pair_reachability_tb.sv
